@@ rtl/smpq_pkg.sv @@
// shared types and constants for the sorted max-priority queue
// no dependencies; imported by spq cell and top level
package smpq_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 16;
    localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic   push;
        logic   pop;
        value_t val;
    } smpq_ctrl_t;

endpackage

@@ rtl/smpq_cell.sv @@
// one slot of the sorted queue: holds an entry and shifts with its neighbours
// depends on smpq_pkg
module smpq_cell
    import smpq_pkg::*;
(
    input  logic       clk,
    input  smpq_ctrl_t ctrl,
    input  logic       occupied,
    input  logic       left_keeps,
    input  value_t     left_entry,
    input  value_t     right_entry,
    output logic       keeps,
    output value_t     entry
);

    value_t entry_reg;
    value_t entry_next;

    // an occupied entry at least as large as the new value stays put
    assign keeps = occupied && (entry_reg >= ctrl.val);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.push && !keeps)
        begin
            // first cell that does not keep takes the new value, the rest shift back
            if (left_keeps)
            begin
                entry_next = ctrl.val;
            end
            else
            begin
                entry_next = left_entry;
            end
        end
        else if (ctrl.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

@@ rtl/sorted_max_priority_queue.sv @@
// Sorted max-priority queue of 16 entries of 16 bits, largest at the front.
// Every command (push, pop, clear, nop) is accepted when start is high: busy never rises,
// so a command can be issued on every clock. Its result appears on the result
// ports, marked by done, in the cycle after the command transfer and for that
// cycle only; the receiver must take it then. The cells compare and shift in
// parallel. Equal values leave in arrival order; a push into a full queue is dropped.
// depends on smpq_pkg and smpq_cell
module sorted_max_priority_queue
    import smpq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [15:0] value,
    output logic        done,
    output logic [15:0] popped_value,
    output logic [1:0]  status,
    output logic [4:0]  entry_count
);

    count_t     count_reg;
    count_t     count_next;
    logic       done_reg;
    value_t     popped_reg;
    value_t     popped_next;
    status_t    status_reg;
    status_t    status_next;
    smpq_ctrl_t ctrl;
    logic       accept;
    logic       full;
    logic       empty;

    logic   keeps [DEPTH];
    value_t entry [DEPTH];
    logic   occupied [DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == count_t'(DEPTH));
    assign empty  = (count_reg == '0);

    assign ctrl.push = accept && (opcode_t'(opcode) == OP_PUSH) && !full;
    assign ctrl.pop  = accept && (opcode_t'(opcode) == OP_POP) && !empty;
    assign ctrl.val  = value_t'(value);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic   left_keeps;
            value_t left_entry;
            value_t right_entry;

            assign occupied[gi] = (count_t'(gi) < count_reg);

            if (gi == 0)
            begin : g_first
                assign left_keeps = 1'b1;
                assign left_entry = ctrl.val;
            end
            else
            begin : g_mid
                assign left_keeps = keeps[gi-1];
                assign left_entry = entry[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign right_entry = entry[gi];
            end
            else
            begin : g_inner
                assign right_entry = entry[gi+1];
            end

            smpq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (occupied[gi]),
                .left_keeps  (left_keeps),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .keeps       (keeps[gi]),
                .entry       (entry[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        popped_next = '0;
        status_next = ST_DONE;
        if (accept)
        begin
            case (opcode_t'(opcode))
                OP_PUSH:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + count_t'(1);
                    end
                end
                OP_POP:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        popped_next = entry[0];
                        count_next  = count_reg - count_t'(1);
                    end
                end
                OP_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // result payload, qualified by done
    always_ff @(posedge clk)
    begin
        popped_reg <= popped_next;
        status_reg <= status_next;
    end

    assign done         = done_reg;
    assign popped_value = 16'(popped_reg);
    assign status       = status_reg;
    assign entry_count  = 5'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= count_t'(DEPTH))
        else $error("entry count above depth");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_FULL) |-> entry_count == 5'(DEPTH))
        else $error("full status with queue not full");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_EMPTY) |-> entry_count == 5'd0 && popped_value == 16'd0)
        else $error("empty status with entries held");

    a_front_largest: assert property (@(posedge clk) disable iff (!rst_n)
        occupied[1] |-> entry[0] >= entry[1])
        else $error("front entry not the largest");

endmodule

@@ bench/sorted_max_priority_queue_tb.sv @@
// self-checking bench for sorted_max_priority_queue: directed then random push/pop/clear traffic
// keeps its own sorted copy of the queue to predict every result; needs smpq_pkg and the rtl
module sorted_max_priority_queue_tb;
    import smpq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 700;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        opcode_t op;
        value_t  val;
    } queue_cmd_t;

    typedef struct {
        value_t  popped;
        status_t st;
        count_t  cnt;
    } queue_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  opcode = OP_NOP;
    logic [15:0] value = '0;
    logic        busy;
    logic        done;
    logic [15:0] popped_value;
    logic [1:0]  status;
    logic [4:0]  entry_count;

    queue_cmd_t    pending_cmds[$];
    queue_result_t expected_results[$];
    value_t        held[DEPTH];
    int            held_count = 0;
    int            mismatch_count = 0;
    int            cycle_count = 0;
    int            idle_left = 0;
    logic          idle_on = 1'b1;
    logic          taken = 1'b0;

    sorted_max_priority_queue u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .value        (value),
        .done         (done),
        .popped_value (popped_value),
        .status       (status),
        .entry_count  (entry_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // applies one command to the shadow queue and returns what the block should report
    function automatic queue_result_t apply_queue_op(logic [1:0] op, value_t val);
        queue_result_t r;
        int pos;
        int i;
        r.popped = '0;
        r.st     = ST_DONE;
        case (op)
            OP_PUSH:
            begin
                if (held_count >= DEPTH)
                    r.st = ST_FULL;
                else
                begin
                    // new value goes behind every entry greater than or equal to it
                    pos = 0;
                    while (pos < held_count && held[pos] >= val)
                        pos++;
                    for (i = held_count; i > pos; i--)
                        held[i] = held[i-1];
                    held[pos] = val;
                    held_count++;
                end
            end
            OP_POP:
            begin
                if (held_count == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    r.popped = held[0];
                    for (i = 0; i + 1 < held_count; i++)
                        held[i] = held[i+1];
                    held_count--;
                end
            end
            OP_CLEAR:
                held_count = 0;
            default:
                ;
        endcase
        r.cnt = count_t'(held_count);
        return r;
    endfunction

    function automatic value_t draw_value(int mode);
        case (mode)
            0:       return value_t'($urandom_range(0, 7));
            1:       return ($urandom_range(0, 1) != 0) ? '1 : '0;
            2:       return value_t'($urandom_range(16'hff00, 16'hffff));
            default: return value_t'($urandom);
        endcase
    endfunction

    // driver: one command per transfer, random idle gaps between them
    always @(negedge clk)
    begin : drive_cmds
        queue_cmd_t cmd;
        if (rst_n && (!start || taken))
        begin
            if (idle_left != 0)
            begin
                start     <= 1'b0;
                idle_left <= idle_left - 1;
            end
            else if (pending_cmds.size() != 0)
            begin
                cmd = pending_cmds.pop_front();
                start  <= 1'b1;
                opcode <= cmd.op;
                value  <= cmd.val;
                if ($urandom_range(0, 39) == 0)
                    idle_on <= !idle_on;
                idle_left <= idle_on ? $urandom_range(0, 17) : 0;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: check the strobed result, then predict for a transfer on this edge
    always @(posedge clk)
    begin : check_results
        queue_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: popped_value %0h status %0d entry_count %0d",
                           popped_value, status, entry_count);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (popped_value !== want.popped)
                    begin
                        $error("popped_value: expected %0h, actual %0h", want.popped, popped_value);
                        mismatch_count++;
                    end
                    if (status !== want.st)
                    begin
                        $error("status: expected %0d, actual %0d", want.st, status);
                        mismatch_count++;
                    end
                    if (entry_count !== want.cnt)
                    begin
                        $error("entry_count: expected %0d, actual %0d", want.cnt, entry_count);
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy)
                expected_results.push_back(apply_queue_op(opcode, value));
            taken <= start && !busy;
        end
        else
            taken <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        queue_cmd_t cmd;
        value_t     fill_vals[8];
        int         n_items;
        int         push_pct;
        int         run_len;
        int         value_mode;
        int         roll;
        int         i;

        // directed: empty pop, idle opcode, fill with extremes and ties, full push, clear
        cmd.op = OP_POP;  cmd.val = 16'h1234; pending_cmds.push_back(cmd);
        cmd.op = OP_NOP;  cmd.val = 16'hffff; pending_cmds.push_back(cmd);
        fill_vals = '{16'hffff, 16'h0000, 16'h8000, 16'h8000,
                      16'h7fff, 16'h0001, 16'hffff, 16'h0000};
        for (i = 0; i < DEPTH; i++)
        begin
            cmd.op  = OP_PUSH;
            cmd.val = (i < 8) ? fill_vals[i] : value_t'($urandom);
            pending_cmds.push_back(cmd);
        end
        cmd.op = OP_PUSH;  cmd.val = 16'h5555; pending_cmds.push_back(cmd);
        cmd.op = OP_POP;   cmd.val = 16'haaaa; pending_cmds.push_back(cmd);
        cmd.op = OP_PUSH;  cmd.val = 16'h0000; pending_cmds.push_back(cmd);
        cmd.op = OP_PUSH;  cmd.val = 16'hffff; pending_cmds.push_back(cmd);
        cmd.op = OP_CLEAR; cmd.val = 16'hffff; pending_cmds.push_back(cmd);
        cmd.op = OP_POP;   cmd.val = 16'h0000; pending_cmds.push_back(cmd);

        // random runs, each leaning towards filling, draining or holding level
        n_items = 0;
        while (n_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 2))
                0:       push_pct = 85;
                1:       push_pct = 50;
                default: push_pct = 20;
            endcase
            value_mode = $urandom_range(0, 3);
            run_len    = $urandom_range(8, 40);
            repeat (run_len)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 2)
                    cmd.op = OP_CLEAR;
                else if (roll < 4)
                    cmd.op = OP_NOP;
                else if (roll < 4 + push_pct * 96 / 100)
                    cmd.op = OP_PUSH;
                else
                    cmd.op = OP_POP;
                cmd.val = draw_value(value_mode);
                pending_cmds.push_back(cmd);
                if (cmd.op != OP_NOP)
                    n_items++;
            end
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
